/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the odometry block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/ddwo_pkg.sv */
// ---------------------------------------------------------------------------
// Odometry package
// Constants and tables shared by the odometry modules.
// ---------------------------------------------------------------------------
package ddwo_pkg;

    localparam logic [31:0] KINV_Q32 = 32'h9B74EDA8;
    localparam logic [31:0] RPM_SCALE = 32'd3932160000;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'd536870912;
                5'd1: r = 32'd316933406;
                5'd2: r = 32'd167458907;
                5'd3: r = 32'd85004756;
                5'd4: r = 32'd42667331;
                5'd5: r = 32'd21354465;
                5'd6: r = 32'd10679838;
                5'd7: r = 32'd5340245;
                5'd8: r = 32'd2670163;
                5'd9: r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                5'd24: r = 32'd41;
                5'd25: r = 32'd20;
                5'd26: r = 32'd10;
                5'd27: r = 32'd5;
                5'd28: r = 32'd3;
                5'd29: r = 32'd1;
                5'd30: r = 32'd1;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
        logic [31:0] r;
        begin
            if (neg)
            begin
                if (mag >= 64'h80000000) r = 32'h80000000;
                else r = 32'd0 - mag[31:0];
            end
            else
            begin
                if (mag > 64'h7FFFFFFF) r = 32'h7FFFFFFF;
                else r = mag[31:0];
            end
            return r;
        end
    endfunction

endpackage

/* hdl/diff_drive_wheel_odometry.sv */
// ---------------------------------------------------------------------------
// Differential-drive wheel odometry
// Forms encoder deltas, wheel speeds, distance, heading change, CORDIC pose
// update and velocities, one item at a time through a shared divider.
// ---------------------------------------------------------------------------
// Each item runs four 64-bit divisions on the shared divider; a zero interval
// skips the divisions. A new item is accepted only in idle, after the previous
// result has been taken past any output stall.
// Reset at once clears pose, heading, stored positions, state and the distance
// and angle scales, sets counts-per-rev to 1, and does not reset datapath registers.
`include "assert_macros.svh"
module diff_drive_wheel_odometry
#(
    parameter int CORDIC_STEPS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [31:0] left_count,
    input  logic signed [31:0] right_count,
    input  logic [15:0] elapsed_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] left_speed,
    output logic signed [31:0] right_speed,
    output logic signed [31:0] pose_x_out,
    output logic signed [31:0] pose_y_out,
    output logic [31:0] heading_out,
    output logic signed [31:0] linear_velocity,
    output logic signed [31:0] angular_velocity,
    output logic        bad_interval
);

    localparam logic [1:0] REG_DIST = 2'd0;
    localparam logic [1:0] REG_ANGLE = 2'd1;
    localparam logic [1:0] REG_CPR = 2'd2;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL = 4'd1;
    localparam logic [3:0] S_PRE = 4'd2;
    localparam logic [3:0] S_ROT = 4'd3;
    localparam logic [3:0] S_DL = 4'd4;
    localparam logic [3:0] S_DR = 4'd5;
    localparam logic [3:0] S_DV = 4'd6;
    localparam logic [3:0] S_DW = 4'd7;
    localparam logic [3:0] S_OUT = 4'd8;
    localparam logic [3:0] S_MAG = 4'd9;

    logic [31:0] dpc_reg;
    logic [31:0] apc_reg;
    logic [15:0] cpr_reg;
    logic [31:0] last_l_reg;
    logic [31:0] last_r_reg;
    logic [31:0] px_reg;
    logic [31:0] py_reg;
    logic [31:0] hd_reg;
    logic [3:0]  st_reg;
    logic        sub_reg;
    logic        ov_reg;

    logic [31:0] dl_reg;
    logic [31:0] dr_reg;
    logic [32:0] sum_reg;
    logic [31:0] dth_reg;
    logic [31:0] ds_reg;
    logic [15:0] ms_reg;
    logic [47:0] den_reg;
    logic [63:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [48:0] xin_reg;

    logic        dv_start;
    logic [63:0] dv_num;
    logic        dv_busy;
    logic [63:0] dv_q;
    logic        cd_start;
    logic        cd_busy;
    logic [31:0] cd_x;
    logic [31:0] cd_y;

    logic [31:0] ls_reg;
    logic [31:0] rs_reg;
    logic [31:0] v_reg;
    logic [31:0] w_reg;
    logic        bad_reg;

    logic [31:0] dlw;
    logic [31:0] drw;
    logic [32:0] sumw;
    logic [32:0] summag;
    logic [31:0] dsmag;
    logic [31:0] cur_mag;
    logic        cur_neg;
    logic [63:0] mag64_prod;
    logic [1:0]  dsel;
    logic [15:0] cpr_eff;
    logic [31:0] cpr_ms;

    ddwo_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (dv_num),
        .divisor  (den_reg),
        .busy     (dv_busy),
        .quotient (dv_q)
    );

    ddwo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cd_start),
        .x_in   (xin_reg),
        .ang_in (hd_reg - dth_reg),
        .busy   (cd_busy),
        .x_out  (cd_x),
        .y_out  (cd_y)
    );

    assign dlw = left_count - last_l_reg;
    assign drw = right_count - last_r_reg;
    assign sumw = {dlw[31], dlw} + {drw[31], drw};
    assign summag = sum_reg[32] ? (33'd0 - sum_reg) : sum_reg;
    assign dsmag = ds_reg[31] ? (32'd0 - ds_reg) : ds_reg;
    assign cpr_eff = (cpr_reg == 16'd0) ? 16'd1 : cpr_reg;
    assign cpr_ms = cpr_eff * ms_reg;

    always_comb
    begin
        dsel = 2'd0;
        case (st_reg)
            S_DL: dsel = 2'd0;
            S_DR: dsel = 2'd1;
            S_DV: dsel = 2'd2;
            S_DW: dsel = 2'd3;
            default: dsel = 2'd0;
        endcase
        cur_mag = '0;
        cur_neg = 1'b0;
        case (dsel)
            2'd0:
            begin
                cur_neg = dl_reg[31];
                cur_mag = dl_reg[31] ? (32'd0 - dl_reg) : dl_reg;
            end
            2'd1:
            begin
                cur_neg = dr_reg[31];
                cur_mag = dr_reg[31] ? (32'd0 - dr_reg) : dr_reg;
            end
            2'd2:
            begin
                cur_neg = ds_reg[31];
                cur_mag = dsmag;
            end
            default:
            begin
                cur_neg = dth_reg[31];
                cur_mag = dth_reg[31] ? (32'd0 - dth_reg) : dth_reg;
            end
        endcase
    end

    always_comb
    begin
        mul_a = {32'd0, dpc_reg};
        mul_b = summag[31:0];
        case (st_reg)
            S_MAG:
            begin
                mul_a = {32'd0, dpc_reg};
                mul_b = summag[31:0];
            end
            S_MUL:
            begin
                mul_a = {32'd0, apc_reg};
                mul_b = dr_reg - dl_reg;
            end
            S_PRE:
            begin
                mul_a = {32'd0, dsmag};
                mul_b = ddwo_pkg::KINV_Q32;
            end
            default:
            begin
                mul_a = {32'd0, cur_mag};
                mul_b = ddwo_pkg::RPM_SCALE;
            end
        endcase
        prod = mul_a[31:0] * mul_b;
    end

    // The sum magnitude may reach 2^32; its top bit adds dist_per_count << 32.
    assign mag64_prod = prod + (summag[32] ? {dpc_reg, 32'd0} : 64'd0);

    assign dv_num = (dsel[1]) ? {32'd0, cur_mag} : prod;
    assign dv_start = (st_reg == S_DL || st_reg == S_DR || st_reg == S_DV ||
                       st_reg == S_DW) && !sub_reg && !bad_reg;
    assign cd_start = (st_reg == S_ROT) && !sub_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpc_reg <= '0;
            apc_reg <= '0;
            cpr_reg <= 16'd1;
            last_l_reg <= '0;
            last_r_reg <= '0;
            px_reg <= '0;
            py_reg <= '0;
            hd_reg <= '0;
            st_reg <= S_IDLE;
            sub_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DIST: dpc_reg <= cfg_data;
                    REG_ANGLE: apc_reg <= cfg_data;
                    REG_CPR: cpr_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            case (st_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        st_reg <= S_MAG;
                    end
                end
                S_MAG: st_reg <= S_MUL;
                S_MUL: st_reg <= S_PRE;
                S_PRE: st_reg <= S_ROT;
                S_ROT:
                begin
                    if (!sub_reg) sub_reg <= 1'b1;
                    else if (!cd_busy)
                    begin
                        sub_reg <= 1'b0;
                        px_reg <= px_reg + cd_x;
                        py_reg <= py_reg + cd_y;
                        hd_reg <= hd_reg + dth_reg;
                        st_reg <= S_DL;
                    end
                end
                S_DL, S_DR, S_DV, S_DW:
                begin
                    if (bad_reg) st_reg <= S_OUT;
                    else if (!sub_reg) sub_reg <= 1'b1;
                    else if (!dv_busy)
                    begin
                        sub_reg <= 1'b0;
                        case (st_reg)
                            S_DL: st_reg <= S_DR;
                            S_DR: st_reg <= S_DV;
                            S_DV: st_reg <= S_DW;
                            default: st_reg <= S_OUT;
                        endcase
                    end
                end
                S_OUT:
                begin
                    if (!out_stall) st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
            if (st_reg == S_IDLE && in_valid)
            begin
                last_l_reg <= left_count;
                last_r_reg <= right_count;
            end
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            S_IDLE:
            begin
                dl_reg <= dlw;
                dr_reg <= drw;
                sum_reg <= sumw;
                ms_reg <= elapsed_ms;
                bad_reg <= (elapsed_ms == 16'd0);
                den_reg <= {32'd0, elapsed_ms};
            end
            S_MAG:
            begin
                ds_reg <= ddwo_pkg::sat32(sum_reg[32], {17'd0, mag64_prod[63:17]});
                den_reg <= {16'd0, cpr_ms};
            end
            S_MUL: dth_reg <= prod[31:0];
            S_PRE:
            begin
                xin_reg <= ds_reg[31] ? (49'd0 - {1'b0, prod[63:16]})
                                      : {1'b0, prod[63:16]};
            end
            S_DL:
            begin
                ls_reg <= '0;
                if (bad_reg)
                begin
                    rs_reg <= '0;
                    v_reg <= '0;
                    w_reg <= '0;
                end
                if (sub_reg && !dv_busy) ls_reg <= ddwo_pkg::sat32(cur_neg, dv_q);
            end
            S_DR:
            begin
                rs_reg <= '0;
                if (sub_reg && !dv_busy)
                begin
                    rs_reg <= ddwo_pkg::sat32(cur_neg, dv_q);
                    den_reg <= {32'd0, ms_reg};
                end
            end
            S_DV:
            begin
                v_reg <= '0;
                if (sub_reg && !dv_busy) v_reg <= ddwo_pkg::sat32(cur_neg, dv_q);
            end
            S_DW:
            begin
                w_reg <= '0;
                if (sub_reg && !dv_busy) w_reg <= ddwo_pkg::sat32(cur_neg, dv_q);
            end
            default: ;
        endcase
    end

    assign in_stall = (st_reg != S_IDLE);
    assign out_valid = (st_reg == S_OUT) && !ov_reg;
    assign left_speed = ls_reg;
    assign right_speed = rs_reg;
    assign pose_x_out = px_reg;
    assign pose_y_out = py_reg;
    assign heading_out = hd_reg;
    assign linear_velocity = v_reg;
    assign angular_velocity = w_reg;
    assign bad_interval = bad_reg;

    `ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && !in_stall, st_reg == S_MAG)
    `ASSERT_IMPL(a_no_div_in_rot, clk, rst_n, st_reg == S_ROT, !dv_busy)
    `ASSERT_IMPL(a_out_holds_input, clk, rst_n, out_valid, in_stall)

endmodule

/* hdl/ddwo_div.sv */
// ---------------------------------------------------------------------------
// Odometry divider
// Restoring divider, 64-bit dividend by 48-bit divisor, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module ddwo_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [47:0] divisor,
    output logic        busy,
    output logic [63:0] quotient
);

    logic [63:0] quo_reg;
    logic [63:0] quo_next;
    logic [48:0] rem_reg;
    logic [48:0] rem_next;
    logic [47:0] dsr_reg;
    logic [47:0] dsr_next;
    logic [6:0]  cnt_reg;
    logic [6:0]  cnt_next;
    logic [49:0] trial;
    logic [49:0] shifted;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        shifted = {rem_reg, quo_reg[63]};
        trial = shifted - {2'b00, dsr_reg};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = 7'd64;
        end
        else if (cnt_reg != 7'd0)
        begin
            cnt_next = cnt_reg - 7'd1;
            if (!trial[49])
            begin
                rem_next = trial[48:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[48:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy = (cnt_reg != 7'd0);
    assign quotient = quo_reg;

endmodule

/* hdl/ddwo_cordic.sv */
// ---------------------------------------------------------------------------
// Odometry CORDIC
// Rotation-mode CORDIC, one iteration a cycle on a shared add-shift unit.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module ddwo_cordic
#(
    parameter int CORDIC_STEPS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [48:0] x_in,
    input  logic [31:0] ang_in,
    output logic        busy,
    output logic [31:0] x_out,
    output logic [31:0] y_out
);

    localparam int CW = 52;

    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_reg;
    logic signed [CW-1:0] y_next;
    logic signed [33:0]   z_reg;
    logic signed [33:0]   z_next;
    logic [5:0]           i_reg;
    logic [5:0]           i_next;
    logic                 run_reg;
    logic                 run_next;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [33:0]   at;
    logic                 quad;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        run_next = run_reg;
        xs = x_reg >>> i_reg[4:0];
        ys = y_reg >>> i_reg[4:0];
        at = {2'b00, ddwo_pkg::atan_entry(i_reg[4:0])};
        quad = ($signed(ang_in) > $signed(32'h40000000)) ||
               ($signed(ang_in) < $signed(32'hC0000000));
        if (start)
        begin
            x_next = quad ? -{{(CW-49){x_in[48]}}, x_in} : {{(CW-49){x_in[48]}}, x_in};
            y_next = '0;
            z_next = quad ? {{2{~ang_in[31]}}, ~ang_in[31], ang_in[30:0]}
                          : {{2{ang_in[31]}}, ang_in};
            i_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            i_next = i_reg + 6'd1;
            if (i_reg == 6'(CORDIC_STEPS - 1)) run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            i_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            i_reg <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign busy = run_reg;
    assign x_out = x_reg[47:16];
    assign y_out = y_reg[47:16];

    `ASSERT_NEXT(a_start_runs, clk, rst_n, start, run_reg && i_reg == 6'd0)
    `ASSERT_IMPL(a_count_bound, clk, rst_n, run_reg, i_reg < 6'(CORDIC_STEPS))
    `ASSERT_NEXT(a_step_adv, clk, rst_n, run_reg && !start, i_reg == $past(i_reg) + 6'd1)

endmodule

/* dv/tb_diff_drive_wheel_odometry.sv */
// ---------------------------------------------------------------------------
// Odometry block testbench
// Sends encoder samples through the valid/stall handshake with bursty input
// and a randomized output stall. Each item's result is checked field by field
// against the testbench's fixed-point predictor or a directed row's expected value.
// ---------------------------------------------------------------------------
module tb_diff_drive_wheel_odometry;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = 24;
    localparam logic [1:0] REG_DIST = 2'd0;
    localparam logic [1:0] REG_ANGLE = 2'd1;
    localparam logic [1:0] REG_CPR = 2'd2;
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 210;

    localparam logic [31:0] ARC_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    typedef struct packed {
        logic [31:0] lspeed;
        logic [31:0] rspeed;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] hdg;
        logic [31:0] lin;
        logic [31:0] ang;
        logic        bad;
    } odo_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [31:0] a;
        logic [31:0] b;
        logic [15:0] ms;
        bit          typed;
        odo_result_t want;
    } row_t;

    localparam int NROWS = 21;

    row_t directed [NROWS] = '{
        '{ROW_ITEM, 32'd0, 32'd0, 16'd0, 1'b1, '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          32'd0, 32'd0, 1'b1}},
        '{ROW_ITEM, 32'd1, 32'd0, 16'd1, 1'b1, '{32'h7FFFFFFF, 32'd0, 32'd0, 32'd0,
          32'd0, 32'd0, 32'd0, 1'b0}},
        '{ROW_ITEM, 32'd0, 32'd0, 16'd1, 1'b1, '{32'h80000000, 32'd0, 32'd0, 32'd0,
          32'd0, 32'd0, 32'd0, 1'b0}},
        '{ROW_ITEM, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 1'b0, '0},
        '{ROW_CFG, {30'd0, REG_CPR}, 32'd0, 16'd0, 1'b0, '0},
        '{ROW_ITEM, 32'h7FFFF000, 32'h80000100, 16'd3, 1'b0, '0},
        '{ROW_CFG, {30'd0, REG_DIST}, 32'hFFFFFFFF, 16'd0, 1'b0, '0},
        '{ROW_CFG, {30'd0, REG_ANGLE}, 32'hFFFFFFFF, 16'd0, 1'b0, '0},
        '{ROW_CFG, {30'd0, REG_CPR}, 32'h0000FFFF, 16'd0, 1'b0, '0},
        '{ROW_CFG, {30'd0, REG_SPARE}, 32'h12345678, 16'd0, 1'b0, '0},
        '{ROW_ITEM, 32'h80000000, 32'h7FFFFFFF, 16'd1, 1'b0, '0},
        '{ROW_ITEM, 32'h7FFFFFFF, 32'h80000000, 16'd0, 1'b0, '0},
        '{ROW_ITEM, 32'hFFFFFFFF, 32'h00000000, 16'hFFFF, 1'b0, '0},
        '{ROW_CFG, {30'd0, REG_DIST}, 32'h00010000, 16'd0, 1'b0, '0},
        '{ROW_CFG, {30'd0, REG_ANGLE}, 32'h01000000, 16'd0, 1'b0, '0},
        '{ROW_CFG, {30'd0, REG_CPR}, 32'd1024, 16'd0, 1'b0, '0},
        '{ROW_ITEM, 32'hFFFFFFF0, 32'h00000050, 16'd10, 1'b0, '0},
        '{ROW_ITEM, 32'hFFFFFFB0, 32'h000000A0, 16'd5, 1'b0, '0},
        '{ROW_ITEM, 32'hFFFFFF00, 32'h000000C0, 16'd7, 1'b0, '0},
        '{ROW_ITEM, 32'h00001000, 32'h00001000, 16'd0, 1'b0, '0},
        '{ROW_ITEM, 32'h00002000, 32'h00002100, 16'd20, 1'b0, '0}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic [15:0] elapsed_ms;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic signed [31:0] left_speed;
    logic signed [31:0] right_speed;
    logic signed [31:0] pose_x_out;
    logic signed [31:0] pose_y_out;
    logic [31:0] heading_out;
    logic signed [31:0] linear_velocity;
    logic signed [31:0] angular_velocity;
    logic        bad_interval;

    logic [31:0] dist_per_count_m;
    logic [31:0] angle_per_diff_m;
    logic [15:0] counts_per_rev_m;
    logic [31:0] last_left_m;
    logic [31:0] last_right_m;
    logic [31:0] pose_x_m;
    logic [31:0] pose_y_m;
    logic [31:0] heading_m;

    odo_result_t pending_poses [$];
    int          errors;
    int          burst_left;
    int          stall_mode = 0;
    int          stall_count = 0;

    diff_drive_wheel_odometry #(.CORDIC_STEPS(STEPS)) u_top (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic logic [31:0] clamp32(bit neg, longint unsigned mag);
        if (neg)
            return mag >= 64'h80000000 ? 32'h80000000 : 32'd0 - mag[31:0];
        return mag > 64'h7FFFFFFF ? 32'h7FFFFFFF : mag[31:0];
    endfunction

    function automatic odo_result_t advance_pose(logic [31:0] lc, logic [31:0] rc,
                                                 logic [15:0] ms);
        odo_result_t r;
        logic [31:0] diff_l;
        logic [31:0] diff_r;
        logic [31:0] ds;
        logic [31:0] dth;
        logic [31:0] ang;
        longint dl;
        longint dr;
        longint dsv;
        longint dthv;
        longint m;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint unsigned den;
        longint unsigned prod;
        begin
            diff_l = lc - last_left_m;
            diff_r = rc - last_right_m;
            dl = $signed(diff_l);
            dr = $signed(diff_r);
            ds = clamp32(dl + dr < 0,
                         (longint'(dist_per_count_m) * magnitude(dl + dr)) >> 17);
            prod = longint'(angle_per_diff_m) * (dr - dl);
            dth = prod[31:0];
            dsv = $signed(ds);
            m = (magnitude(dsv) * longint'(ddwo_pkg::KINV_Q32)) >> 16;
            x = dsv < 0 ? -m : m;
            y = 0;
            ang = heading_m - dth;
            if (longint'($signed(ang)) > 64'sh40000000 ||
                longint'($signed(ang)) < -64'sh40000000)
            begin
                x = -x;
                ang = ang + 32'h80000000;
            end
            z = $signed(ang);
            for (int i = 0; i < STEPS && i < 32; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(ARC_TAB[i]);
                end
                else
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(ARC_TAB[i]);
                end
            end
            xs = x >>> 16;
            ys = y >>> 16;
            pose_x_m = pose_x_m + xs[31:0];
            pose_y_m = pose_y_m + ys[31:0];
            heading_m = heading_m + dth;
            last_left_m = lc;
            last_right_m = rc;
            r = '0;
            r.px = pose_x_m;
            r.py = pose_y_m;
            r.hdg = heading_m;
            r.bad = (ms == 16'd0);
            if (!r.bad)
            begin
                den = longint'(counts_per_rev_m == 16'd0 ? 16'd1 : counts_per_rev_m) * ms;
                dthv = $signed(dth);
                r.lspeed = clamp32(dl < 0,
                                   magnitude(dl) * longint'(ddwo_pkg::RPM_SCALE) / den);
                r.rspeed = clamp32(dr < 0,
                                   magnitude(dr) * longint'(ddwo_pkg::RPM_SCALE) / den);
                r.lin = clamp32(dsv < 0, magnitude(dsv) / ms);
                r.ang = clamp32(dthv < 0, magnitude(dthv) / ms);
            end
            return r;
        end
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    always @(negedge clk)
    begin
        odo_result_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_poses.size() == 0)
            begin
                $error("result with no item outstanding");
                errors++;
            end
            else
            begin
                w = pending_poses.pop_front();
                compare_field("left_speed", w.lspeed, left_speed);
                compare_field("right_speed", w.rspeed, right_speed);
                compare_field("pose_x_out", w.px, pose_x_out);
                compare_field("pose_y_out", w.py, pose_y_out);
                compare_field("heading_out", w.hdg, heading_out);
                compare_field("linear_velocity", w.lin, linear_velocity);
                compare_field("angular_velocity", w.ang, angular_velocity);
                compare_field("bad_interval", {31'd0, w.bad}, {31'd0, bad_interval});
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_count == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_count <= $urandom_range(100, 600);
        end
        else
            stall_count <= stall_count - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    task automatic send_sample(logic [31:0] lc, logic [31:0] rc, logic [15:0] ms,
                               bit typed, odo_result_t want);
        odo_result_t r;
        begin
            in_valid <= 1'b1;
            left_count <= lc;
            right_count <= rc;
            elapsed_ms <= ms;
            do
                @(negedge clk);
            while (in_stall);
            @(posedge clk);
            r = advance_pose(lc, rc, ms);
            pending_poses.push_back(typed ? want : r);
            burst_left--;
            if (burst_left <= 0)
            begin
                in_valid <= 1'b0;
                burst_left = $urandom_range(1, 12);
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    endtask

    task automatic write_register(logic [1:0] idx, logic [31:0] data);
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            wait (pending_poses.size() == 0);
            repeat (4) @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= data;
            @(posedge clk);
            cfg_we <= 1'b0;
            case (idx)
                REG_DIST: dist_per_count_m = data;
                REG_ANGLE: angle_per_diff_m = data;
                REG_CPR: counts_per_rev_m = data[15:0];
                default: ;
            endcase
        end
    endtask

    function automatic logic [31:0] pick_word(int sel);
        case (sel)
            0: return 32'd0;
            1: return 32'hFFFFFFFF;
            2: return $urandom();
            default: return $urandom_range(1, 32'h00100000) << $urandom_range(0, 12);
        endcase
    endfunction

    function automatic logic [31:0] step_from(logic [31:0] last);
        int sh;
        begin
            sh = $urandom_range(0, 14);
            return last + ($urandom_range(0, 2 ** sh) - 2 ** (sh - 1 < 0 ? 0 : sh - 1));
        end
    endfunction

    initial
    begin
        int kind;
        logic [31:0] lc;
        logic [31:0] rc;
        logic [15:0] ms;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_DIST;
        cfg_data = '0;
        in_valid = 1'b0;
        left_count = '0;
        right_count = '0;
        elapsed_ms = '0;
        errors = 0;
        burst_left = 3;
        dist_per_count_m = '0;
        angle_per_diff_m = '0;
        counts_per_rev_m = 16'd1;
        last_left_m = '0;
        last_right_m = '0;
        pose_x_m = '0;
        pose_y_m = '0;
        heading_m = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NROWS; i++)
        begin
            if (directed[i].kind == ROW_CFG)
                write_register(directed[i].a[1:0], directed[i].b);
            else
                send_sample(directed[i].a, directed[i].b, directed[i].ms,
                            directed[i].typed, directed[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_register(REG_DIST, pick_word(p < 2 ? p : $urandom_range(2, 3)));
            write_register(REG_ANGLE, pick_word(p < 2 ? p : $urandom_range(2, 3)));
            case (p % 4)
                0: write_register(REG_CPR, 32'd1);
                1: write_register(REG_CPR, 32'h0000FFFF);
                2: write_register(REG_CPR, 32'd0);
                default: write_register(REG_CPR, $urandom_range(1, 4096));
            endcase
            if (p == 3)
                write_register(REG_SPARE, $urandom());
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 80)
                begin
                    lc = step_from(last_left_m);
                    rc = step_from(last_right_m);
                    ms = 16'($urandom_range(1, 50));
                end
                else if (kind < 92)
                begin
                    lc = $urandom();
                    rc = $urandom();
                    ms = 16'($urandom());
                end
                else
                begin
                    lc = step_from(last_left_m);
                    rc = $urandom();
                    ms = (kind < 96) ? 16'd0 : 16'hFFFF;
                end
                send_sample(lc, rc, ms, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        wait (pending_poses.size() == 0);
        repeat (400) @(posedge clk);
        if (errors == 0 && pending_poses.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/ddwo_pkg.sv
hdl/ddwo_div.sv
hdl/ddwo_cordic.sv
hdl/diff_drive_wheel_odometry.sv
dv/tb_diff_drive_wheel_odometry.sv
